@@ hw/rtl/ecal_pkg.sv @@
// ecal_pkg: shared types, constants and the month-length table for the
// epoch seconds to calendar converter. No dependencies.
package ecal_pkg;

    localparam int SECONDS_BITS_DEF = 34;
    localparam int IN_SEC_W         = 34;
    localparam int US_W             = 20;
    localparam int YEAR_W           = 12;

    localparam int SECS_PER_DAY   = 86400;
    localparam int SECS_PER_HOUR  = 3600;
    localparam int SECS_PER_MIN   = 60;
    localparam int DAYS_PER_400Y  = 146097;
    localparam int YEARS_PER_ERA  = 400;
    localparam int BASE_YEAR      = 1970;
    localparam int DAYS_YEAR      = 365;
    localparam int DAYS_LEAP_YEAR = 366;
    localparam int TOD_W          = 17;

    typedef struct packed {
        logic [IN_SEC_W-1:0] epoch_seconds;
        logic [US_W-1:0]     sub_second_us;
    } t_in;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic [4:0]        hour;
        logic [5:0]        minute;
        logic [5:0]        second;
        logic [US_W-1:0]   microsecond;
    } t_out;

    // month index 0..11, February stretched in leap years
    function automatic logic [4:0] mon_len(input logic [3:0] m, input logic is_leap);
        logic [4:0] n;
        case (m)
            4'd1:                      n = is_leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

@@ hw/rtl/ecal_cmpsub.sv @@
// ecal_cmpsub: shared compare-and-subtract unit used by every step of the
// converter. Depends on nothing.
module ecal_cmpsub #(
    parameter int W = 35
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic         o_ge,
    output logic [W-1:0] o_diff
);
    logic [W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[W];
    assign o_diff = w_sub[W-1:0];
endmodule

@@ hw/rtl/epoch_seconds_to_calendar.sv @@
// epoch_seconds_to_calendar: Unix seconds to Gregorian date and time of day.
// Uses ecal_pkg and ecal_cmpsub.
//
// Input channel i_in / i_in_valid / o_in_stall carries one t_in beat: whole
// seconds since 1970-01-01 and a microsecond fraction. Output channel
// o_out / o_out_valid / i_out_stall carries one t_out beat per input beat.
// A beat moves at a rising edge where valid is high and stall is low.
//
// One compare-and-subtract unit does all the work under a small sequencer:
//   seconds / 86400 by restoring division
//   400-year spans removed by division
//   single years removed one at a time
//   months removed
//   hours, then minutes removed
// o_in_stall is high from acceptance until the result is loaded into the
// output register; the next beat may then enter while that result waits.
// If the output register is still full and stalled the sequencer holds its last step.
// Reset clears the sequencer and the output valid; nothing else.
module epoch_seconds_to_calendar
    import ecal_pkg::*;
#(
    parameter int SECONDS_BITS = SECONDS_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in,
    input  logic i_in_valid,
    output logic o_in_stall,
    output t_out o_out,
    output logic o_out_valid,
    input  logic i_out_stall
);
    localparam int W  = SECONDS_BITS + 1;
    localparam int QB = SECONDS_BITS - 16;
    localparam int KW = $clog2(QB);
    localparam logic [W-1:0] SEC_MASK = {W{1'b1}} >> (W - SECONDS_BITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DDAY = 3'd1;
    localparam logic [2:0] S_DERA = 3'd2;
    localparam logic [2:0] S_YEAR = 3'd3;
    localparam logic [2:0] S_MON  = 3'd4;
    localparam logic [2:0] S_HOUR = 3'd5;
    localparam logic [2:0] S_MIN  = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [W-1:0]      r_acc, n_acc;
    logic [KW-1:0]     r_k, n_k;
    logic [QB-1:0]     r_q, n_q;
    logic [TOD_W-1:0]  r_tod, n_tod;
    logic [YEAR_W-1:0] r_year, n_year;
    logic [1:0]        r_y4, n_y4;
    logic [6:0]        r_y100, n_y100;
    logic [8:0]        r_y400, n_y400;
    logic [3:0]        r_mon, n_mon;
    logic [4:0]        r_day, n_day;
    logic [4:0]        r_hour, n_hour;
    logic [5:0]        r_min, n_min;
    logic [US_W-1:0]   r_us, n_us;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [W-1:0] w_b;
    logic [W-1:0] w_diff;
    logic         w_ge;
    logic         w_leap;
    logic         w_out_free;

    ecal_cmpsub #(.W(W)) u_cmpsub (
        .i_a    (r_acc),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    assign w_leap     = ((r_y4 == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out      = r_out;
    assign o_out_valid = r_out_valid;

    always_comb begin
        unique case (r_state)
            S_DDAY:  w_b = W'(SECS_PER_DAY) << r_k;
            S_DERA:  w_b = W'(DAYS_PER_400Y) << r_k;
            S_YEAR:  w_b = w_leap ? W'(DAYS_LEAP_YEAR) : W'(DAYS_YEAR);
            S_MON:   w_b = W'(mon_len(r_mon, w_leap));
            S_HOUR:  w_b = W'(SECS_PER_HOUR);
            S_MIN:   w_b = W'(SECS_PER_MIN);
            default: w_b = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_k         = r_k;
        n_q         = r_q;
        n_tod       = r_tod;
        n_year      = r_year;
        n_y4        = r_y4;
        n_y100      = r_y100;
        n_y400      = r_y400;
        n_mon       = r_mon;
        n_day       = r_day;
        n_hour      = r_hour;
        n_min       = r_min;
        n_us        = r_us;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_acc   = W'(i_in.epoch_seconds) & SEC_MASK;
                    n_us    = i_in.sub_second_us;
                    n_k     = KW'(QB - 1);
                    n_q     = '0;
                    n_year  = YEAR_W'(BASE_YEAR);
                    n_y4    = 2'(BASE_YEAR % 4);
                    n_y100  = 7'(BASE_YEAR % 100);
                    n_y400  = 9'(BASE_YEAR % YEARS_PER_ERA);
                    n_mon   = '0;
                    n_hour  = '0;
                    n_min   = '0;
                    n_state = S_DDAY;
                end
            end
            S_DDAY: begin
                if (w_ge) begin
                    n_acc      = w_diff;
                    n_q[r_k]   = 1'b1;
                end
                if (r_k == '0) begin
                    n_tod   = n_acc[TOD_W-1:0];
                    n_acc   = W'(n_q);
                    n_k     = KW'(QB - 1);
                    n_state = S_DERA;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_DERA: begin
                if (w_ge) begin
                    n_acc  = w_diff;
                    n_year = r_year + (YEAR_W'(YEARS_PER_ERA) << r_k);
                end
                if (r_k == '0) begin
                    n_state = S_YEAR;
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            S_YEAR: begin
                if (w_ge) begin
                    n_acc  = w_diff;
                    n_year = r_year + 1'b1;
                    n_y4   = r_y4 + 1'b1;
                    n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 1'b1;
                    n_y400 = (r_y400 == 9'(YEARS_PER_ERA - 1)) ? 9'd0 : r_y400 + 1'b1;
                end else begin
                    n_state = S_MON;
                end
            end
            S_MON: begin
                if (w_ge && (r_mon != 4'd11)) begin
                    n_acc = w_diff;
                    n_mon = r_mon + 1'b1;
                end else begin
                    n_day   = r_acc[4:0] + 5'd1;
                    n_acc   = W'(r_tod);
                    n_state = S_HOUR;
                end
            end
            S_HOUR: begin
                if (w_ge) begin
                    n_acc  = w_diff;
                    n_hour = r_hour + 1'b1;
                end else begin
                    n_state = S_MIN;
                end
            end
            S_MIN: begin
                if (w_ge) begin
                    n_acc = w_diff;
                    n_min = r_min + 1'b1;
                end else if (w_out_free) begin
                    n_out.year        = r_year;
                    n_out.month       = r_mon + 4'd1;
                    n_out.day         = r_day;
                    n_out.hour        = r_hour;
                    n_out.minute      = r_min;
                    n_out.second      = r_acc[5:0];
                    n_out.microsecond = r_us;
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_acc  <= n_acc;
        r_k    <= n_k;
        r_q    <= n_q;
        r_tod  <= n_tod;
        r_year <= n_year;
        r_y4   <= n_y4;
        r_y100 <= n_y100;
        r_y400 <= n_y400;
        r_mon  <= n_mon;
        r_day  <= n_day;
        r_hour <= n_hour;
        r_min  <= n_min;
        r_us   <= n_us;
        r_out  <= n_out;
    end
endmodule
